// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is low.
`define RHTS_ASSERT_IMPL(name, clk, rstn, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is low.
`define RHTS_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/rhts_pkg.sv =====
`timescale 1ns / 1ps
// Package of the ray hit splatter: sizes, fixed-point widths, codes and the
// structs passed between the sequencer, the shared unit, the track RAM and the top.
package rhts_pkg;

	// Track store and spread limit
	localparam int TRACK_DEPTH = 65536;
	localparam int MAX_SPREAD  = 4096;
	localparam int TRACK_AW    = $clog2(TRACK_DEPTH);

	// Field widths
	localparam int RATE_W   = 18;
	localparam int AMP_W    = 24;
	localparam int TIME_W   = 32;
	localparam int LEN_W    = 24;
	localparam int RIDX_W   = 16;
	localparam int SAMPLE_W = 32;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

	// Fixed-point bookkeeping
	localparam int TIME_FRAC  = 24;                 // Q8.24 arrival time
	localparam int LEN_FRAC   = 8;                  // Q16.8 path length
	localparam int LEN_SCALE  = 24;                 // length is scaled by 2^24 before sqrt
	localparam int WIDTH_FRAC = 16;                 // sqrt result is Q8.16
	localparam int PEAK_SHIFT = 17;                 // 2 * amp * 2^16
	localparam int START_W    = TIME_W + RATE_W - TIME_FRAC;
	localparam int IDX_W      = START_W + 1;        // start plus spread offset
	localparam int SQ_W       = LEN_W + LEN_SCALE;  // radicand width
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int WIDTH_W    = SQ_W / 2;           // root width
	localparam int NF_W       = WIDTH_W - WIDTH_FRAC;
	localparam int N_W        = $clog2(MAX_SPREAD + 1);
	localparam int DIVD_W     = AMP_W + PEAK_SHIFT;
	// width is at least 2^(LEN_SCALE/2) for any nonzero length
	localparam int PEAK_W     = DIVD_W - LEN_SCALE / 2;
	localparam int UNIT_W     = SQ_W;
	localparam int CNT_W      = $clog2(DIVD_W);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Item kinds
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// Configuration port
	localparam int APB_AW = 3;
	localparam logic [APB_AW-3:0] REG_SAMPLE_RATE = '0;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_SQRT,
		ST_NCALC,
		ST_DIV_PEAK,
		ST_DIV_STEP,
		ST_SPREAD,
		ST_READ
	} seq_state_t;

	typedef struct packed {
		logic                rd_en;
		logic [TRACK_AW-1:0] rd_addr;
		logic                wr_en;
		logic [TRACK_AW-1:0] wr_addr;
		logic [SAMPLE_W-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic              ge;
		logic [UNIT_W-1:0] diff;
	} unit_res_t;

	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] value;
		logic                present;
		logic                overflow;
	} rd_result_t;

endpackage

// ===== hdl/ray_hit_triangle_splatter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ray hit splatter: APB register, result register and the sequencer,
// shared unit and track RAM. Depends on rhts_pkg, rhts_seq, rhts_cmp_sub and rhts_track_ram.
//
//  channel | signals                                      | beat
//  --------+----------------------------------------------+---------------------------
//  in      | in_valid/in_ready, kind, amplitude,           | one hit record or one read
//          | arrival_time, path_length, read_index         |
//  out     | out_valid/out_ready, sample_value,            | one track entry and flags
//          | samples_present, overflow_seen                |
//  apb     | psel, penable, pwrite, paddr, pwdata, prdata  | sample_rate at word 0
//
// Record beat: the multiply state, 24 square-root steps, the n calculation, 41 + 29
// division steps on the shared compare-subtract unit, then read-add-write of up to n
// entries through the separate read and write ports of the track RAM. Zero-length records
// leave the sequencer idle. Read beat: through the RAM read register to the result register,
// held there while out_ready is low. After reset a clearing pass writes zero to all 65536
// entries; in_ready stays low meanwhile, APB writes are taken at any time.
module ray_hit_triangle_splatter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic signed [rhts_pkg::AMP_W-1:0]   amplitude,
	input  logic [rhts_pkg::TIME_W-1:0]         arrival_time,
	input  logic [rhts_pkg::LEN_W-1:0]          path_length,
	input  logic [rhts_pkg::RIDX_W-1:0]         read_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [rhts_pkg::SAMPLE_W-1:0] sample_value,
	output logic                                samples_present,
	output logic                                overflow_seen,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rhts_pkg::APB_AW-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic [rhts_pkg::RATE_W-1:0]   rate_q;
	logic                          out_valid_q;
	logic [rhts_pkg::SAMPLE_W-1:0] sample_q;
	logic                          present_q;
	logic                          ovf_q;
	logic                          out_free;
	logic                          reg_hit;

	rhts_pkg::rd_result_t          rd_res;
	rhts_pkg::mem_req_t            mem_req;
	logic [rhts_pkg::SAMPLE_W-1:0] mem_rdata;
	logic [rhts_pkg::UNIT_W-1:0]   unit_a;
	logic [rhts_pkg::UNIT_W-1:0]   unit_b;
	rhts_pkg::unit_res_t           unit_res;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[rhts_pkg::APB_AW-1:2] == rhts_pkg::REG_SAMPLE_RATE);
	assign prdata  = reg_hit ? 32'(rate_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= rhts_pkg::RATE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			rate_q <= pwdata[rhts_pkg::RATE_W-1:0];
		end
	end

	// Result register parts the sequencer from the consumer
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_res.valid) begin
			sample_q  <= rd_res.value;
			present_q <= rd_res.present;
			ovf_q     <= rd_res.overflow;
		end
	end

	assign out_valid       = out_valid_q;
	assign sample_value    = sample_q;
	assign samples_present = present_q;
	assign overflow_seen   = ovf_q;

	rhts_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.amplitude    (amplitude),
		.arrival_time (arrival_time),
		.path_length  (path_length),
		.read_index   (read_index),
		.sample_rate  (rate_q),
		.out_free     (out_free),
		.rd_res       (rd_res),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.unit_a       (unit_a),
		.unit_b       (unit_b),
		.unit_res     (unit_res)
	);

	rhts_cmp_sub u_unit (
		.a   (unit_a),
		.b   (unit_b),
		.res (unit_res)
	);

	rhts_track_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

// ===== hdl/rhts_cmp_sub.sv =====
`timescale 1ns / 1ps
// Shared compare-and-subtract unit used by the square root and both divisions.
// Depends on rhts_pkg for the operand width and the result struct.
module rhts_cmp_sub (
	input  logic [rhts_pkg::UNIT_W-1:0] a,
	input  logic [rhts_pkg::UNIT_W-1:0] b,
	output rhts_pkg::unit_res_t         res
);

	always_comb begin
		res.ge   = (a >= b);
		res.diff = a - b;
	end

endmodule

// ===== hdl/rhts_track_ram.sv =====
`timescale 1ns / 1ps
// Impulse-response track store: one write port, one read port, registered read data.
// Depends on rhts_pkg for depth, widths and the request struct.
module rhts_track_ram (
	input  logic                          clk,
	input  rhts_pkg::mem_req_t            req,
	output logic [rhts_pkg::SAMPLE_W-1:0] rdata
);

	logic [rhts_pkg::SAMPLE_W-1:0] mem [rhts_pkg::TRACK_DEPTH];
	logic [rhts_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/rhts_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the splatter: clearing pass, start index, square root, two divisions,
// ramp accumulation and reads. Depends on rhts_pkg, drives rhts_cmp_sub and the track RAM.
module rhts_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic signed [rhts_pkg::AMP_W-1:0]  amplitude,
	input  logic [rhts_pkg::TIME_W-1:0]        arrival_time,
	input  logic [rhts_pkg::LEN_W-1:0]         path_length,
	input  logic [rhts_pkg::RIDX_W-1:0]        read_index,
	input  logic [rhts_pkg::RATE_W-1:0]        sample_rate,
	input  logic                               out_free,
	output rhts_pkg::rd_result_t               rd_res,
	output rhts_pkg::mem_req_t                 mem_req,
	input  logic [rhts_pkg::SAMPLE_W-1:0]      mem_rdata,
	output logic [rhts_pkg::UNIT_W-1:0]        unit_a,
	output logic [rhts_pkg::UNIT_W-1:0]        unit_b,
	input  rhts_pkg::unit_res_t                unit_res
);

	rhts_pkg::seq_state_t state_q, state_d;

	logic [rhts_pkg::TRACK_AW-1:0]  clr_addr_q;
	logic [rhts_pkg::CNT_W-1:0]     cnt_q;
	logic                           neg_q;
	logic [rhts_pkg::AMP_W-1:0]     mag_q;
	logic [rhts_pkg::TIME_W-1:0]    time_q;
	logic [rhts_pkg::LEN_W-1:0]     len_q;
	logic [rhts_pkg::START_W-1:0]   start_q;
	logic [rhts_pkg::SQ_W-1:0]      x_q;
	logic [rhts_pkg::SQ_W-1:0]      root_q;
	logic [rhts_pkg::SQ_W-1:0]      bit_q;
	logic [rhts_pkg::N_W-1:0]       n_q;
	logic [rhts_pkg::WIDTH_W-1:0]   rem_q;
	logic [rhts_pkg::DIVD_W-1:0]    dq_q;
	logic [rhts_pkg::PEAK_W-1:0]    peak_q;
	logic [rhts_pkg::PEAK_W-1:0]    step_q;
	logic [rhts_pkg::PEAK_W-1:0]    vmag_q;
	logic [rhts_pkg::N_W-1:0]       issue_q;
	logic                           issue_done_q;
	logic                           rd_oor_q;
	logic                           any_hit_q;
	logic                           ovf_q;

	logic                           pend_s1;
	logic [rhts_pkg::TRACK_AW-1:0]  addr_s1;
	logic [rhts_pkg::PEAK_W:0]      val_s1;

	logic                           issue_go;
	logic                           drop_go;
	logic                           accept;
	logic [rhts_pkg::IDX_W-1:0]     idx;
	logic [rhts_pkg::DIVD_W-1:0]    q_next;
	logic [rhts_pkg::TIME_W+rhts_pkg::RATE_W-1:0] prod;
	logic [rhts_pkg::NF_W-1:0]      n0;
	logic [2*rhts_pkg::NF_W-1:0]    nsq;
	logic [rhts_pkg::NF_W:0]        n1;
	logic [rhts_pkg::SAMPLE_W:0]    sum_w;
	logic [rhts_pkg::SAMPLE_W-1:0]  sat_sum;
	logic                           sat_ovf;
	logic [rhts_pkg::AMP_W-1:0]     amp_u;

	assign accept = in_valid && in_ready;
	assign idx    = {1'b0, start_q} + rhts_pkg::IDX_W'(issue_q);
	assign q_next = {dq_q[rhts_pkg::DIVD_W-2:0], unit_res.ge};
	assign prod   = time_q * sample_rate;
	assign n0     = root_q[rhts_pkg::WIDTH_W-1:rhts_pkg::WIDTH_FRAC];
	assign nsq    = n0 * n0;
	assign n1     = {1'b0, n0} + rhts_pkg::NF_W'({nsq, {rhts_pkg::LEN_FRAC{1'b0}}} < len_q);
	assign amp_u  = amplitude;

	// Saturating add of the ramp value onto the stored entry
	always_comb begin
		sum_w = {mem_rdata[rhts_pkg::SAMPLE_W-1], mem_rdata}
			+ {{(rhts_pkg::SAMPLE_W-rhts_pkg::PEAK_W){val_s1[rhts_pkg::PEAK_W]}}, val_s1};
		sat_ovf = sum_w[rhts_pkg::SAMPLE_W] != sum_w[rhts_pkg::SAMPLE_W-1];
		if (!sat_ovf) begin
			sat_sum = sum_w[rhts_pkg::SAMPLE_W-1:0];
		end else if (sum_w[rhts_pkg::SAMPLE_W]) begin
			sat_sum = rhts_pkg::SAMPLE_MIN;
		end else begin
			sat_sum = rhts_pkg::SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhts_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_req  = '0;
		unit_a   = '0;
		unit_b   = '0;
		rd_res   = '0;
		issue_go = 1'b0;
		drop_go  = 1'b0;
		case (state_q)
			rhts_pkg::ST_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = clr_addr_q;
				if (clr_addr_q == rhts_pkg::TRACK_AW'(rhts_pkg::TRACK_DEPTH - 1)) begin
					state_d = rhts_pkg::ST_IDLE;
				end
			end
			rhts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == rhts_pkg::KIND_READ) begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = rhts_pkg::TRACK_AW'(read_index);
						state_d         = rhts_pkg::ST_READ;
					end else if (path_length != '0) begin
						state_d = rhts_pkg::ST_MUL;
					end
				end
			end
			rhts_pkg::ST_MUL: begin
				state_d = rhts_pkg::ST_SQRT;
			end
			rhts_pkg::ST_SQRT: begin
				// root and bit never overlap, so OR gives root + bit
				unit_a = x_q;
				unit_b = root_q | bit_q;
				if (cnt_q == rhts_pkg::CNT_W'(rhts_pkg::SQRT_STEPS - 1)) begin
					state_d = rhts_pkg::ST_NCALC;
				end
			end
			rhts_pkg::ST_NCALC: begin
				state_d = rhts_pkg::ST_DIV_PEAK;
			end
			rhts_pkg::ST_DIV_PEAK: begin
				unit_a = rhts_pkg::UNIT_W'({rem_q, dq_q[rhts_pkg::DIVD_W-1]});
				unit_b = rhts_pkg::UNIT_W'(root_q[rhts_pkg::WIDTH_W-1:0]);
				if (cnt_q == rhts_pkg::CNT_W'(rhts_pkg::DIVD_W - 1)) begin
					state_d = rhts_pkg::ST_DIV_STEP;
				end
			end
			rhts_pkg::ST_DIV_STEP: begin
				unit_a = rhts_pkg::UNIT_W'({rem_q[rhts_pkg::N_W-1:0], dq_q[rhts_pkg::PEAK_W-1]});
				unit_b = rhts_pkg::UNIT_W'(n_q);
				if (cnt_q == rhts_pkg::CNT_W'(rhts_pkg::PEAK_W - 1)) begin
					state_d = rhts_pkg::ST_SPREAD;
				end
			end
			rhts_pkg::ST_SPREAD: begin
				// Read ahead one entry while the previous one is written back
				if (!issue_done_q && issue_q != n_q) begin
					if (idx >= rhts_pkg::IDX_W'(rhts_pkg::TRACK_DEPTH)) begin
						drop_go = 1'b1;
					end else begin
						issue_go        = 1'b1;
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = idx[rhts_pkg::TRACK_AW-1:0];
					end
				end
				if (pend_s1) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = addr_s1;
					mem_req.wr_data = sat_sum;
				end
				if (issue_done_q && !pend_s1) begin
					state_d = rhts_pkg::ST_IDLE;
				end
			end
			rhts_pkg::ST_READ: begin
				rd_res.valid    = out_free;
				rd_res.value    = rd_oor_q ? '0 : mem_rdata;
				rd_res.present  = any_hit_q;
				rd_res.overflow = ovf_q;
				if (out_free) begin
					state_d = rhts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rhts_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			pend_s1      <= 1'b0;
			issue_done_q <= 1'b0;
			any_hit_q    <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			if (state_q == rhts_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			pend_s1 <= issue_go;
			if (state_q == rhts_pkg::ST_DIV_STEP) begin
				issue_done_q <= 1'b0;
			end else if (state_q == rhts_pkg::ST_SPREAD && (drop_go || issue_q == n_q)) begin
				issue_done_q <= 1'b1;
			end
			if (pend_s1) begin
				any_hit_q <= 1'b1;
			end
			if (drop_go || (pend_s1 && sat_ovf)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rhts_pkg::ST_IDLE: begin
				if (accept) begin
					neg_q    <= amp_u[rhts_pkg::AMP_W-1];
					mag_q    <= amp_u[rhts_pkg::AMP_W-1] ? (~amp_u + 1'b1) : amp_u;
					time_q   <= arrival_time;
					len_q    <= path_length;
					rd_oor_q <= (32'(read_index) >= 32'(rhts_pkg::TRACK_DEPTH));
				end
			end
			rhts_pkg::ST_MUL: begin
				start_q <= prod[rhts_pkg::TIME_W+rhts_pkg::RATE_W-1 -: rhts_pkg::START_W];
				x_q     <= {len_q, {rhts_pkg::LEN_SCALE{1'b0}}};
				root_q  <= '0;
				bit_q   <= {2'b01, {(rhts_pkg::SQ_W-2){1'b0}}};
				cnt_q   <= '0;
			end
			rhts_pkg::ST_SQRT: begin
				if (unit_res.ge) begin
					x_q    <= unit_res.diff;
					root_q <= (root_q >> 1) | bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
			end
			rhts_pkg::ST_NCALC: begin
				if (int'(n1) > rhts_pkg::MAX_SPREAD) begin
					n_q <= rhts_pkg::N_W'(rhts_pkg::MAX_SPREAD);
				end else begin
					n_q <= rhts_pkg::N_W'(n1);
				end
				rem_q <= '0;
				dq_q  <= {mag_q, {rhts_pkg::PEAK_SHIFT{1'b0}}};
				cnt_q <= '0;
			end
			rhts_pkg::ST_DIV_PEAK: begin
				if (cnt_q == rhts_pkg::CNT_W'(rhts_pkg::DIVD_W - 1)) begin
					peak_q <= q_next[rhts_pkg::PEAK_W-1:0];
					dq_q   <= rhts_pkg::DIVD_W'(q_next[rhts_pkg::PEAK_W-1:0]);
					rem_q  <= '0;
					cnt_q  <= '0;
				end else begin
					rem_q <= unit_res.ge ? unit_res.diff[rhts_pkg::WIDTH_W-1:0]
						: unit_a[rhts_pkg::WIDTH_W-1:0];
					dq_q  <= q_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			rhts_pkg::ST_DIV_STEP: begin
				rem_q <= unit_res.ge ? unit_res.diff[rhts_pkg::WIDTH_W-1:0]
					: unit_a[rhts_pkg::WIDTH_W-1:0];
				dq_q  <= q_next;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rhts_pkg::CNT_W'(rhts_pkg::PEAK_W - 1)) begin
					step_q  <= q_next[rhts_pkg::PEAK_W-1:0];
					vmag_q  <= peak_q;
					issue_q <= '0;
				end
			end
			rhts_pkg::ST_SPREAD: begin
				if (issue_go) begin
					addr_s1 <= idx[rhts_pkg::TRACK_AW-1:0];
					val_s1  <= neg_q ? (~{1'b0, vmag_q} + 1'b1) : {1'b0, vmag_q};
					vmag_q  <= vmag_q - step_q;
					issue_q <= issue_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/rhts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the ray hit splatter, bound to the top level.
// Depends on assert_macros.svh and rhts_pkg for the port widths.
`include "assert_macros.svh"

module rhts_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                kind,
	input logic signed [rhts_pkg::AMP_W-1:0]   amplitude,
	input logic [rhts_pkg::TIME_W-1:0]         arrival_time,
	input logic [rhts_pkg::LEN_W-1:0]          path_length,
	input logic [rhts_pkg::RIDX_W-1:0]         read_index,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [rhts_pkg::SAMPLE_W-1:0] sample_value,
	input logic                                samples_present,
	input logic                                overflow_seen,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [rhts_pkg::APB_AW-1:0]         paddr,
	input logic [31:0]                         pwdata,
	input logic [31:0]                         prdata,
	input logic                                pready
);

	// A stalled result holds its value
	`RHTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_value) && $stable(overflow_seen), "stalled result changed")

	// A record beat never produces a result
	`RHTS_ASSERT_NEXT(a_record_silent, clk, arst_n, in_valid && in_ready && (kind == rhts_pkg::KIND_RECORD) && !out_valid, !out_valid, "record beat produced a result")

	// Any beat with work to do makes the block busy on the next cycle
	`RHTS_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_valid && in_ready && ((kind == rhts_pkg::KIND_READ) || (path_length != '0)), !in_ready, "ready while an item is in work")

	// A read into an empty result register shows up after the RAM read register and the result register
	`RHTS_ASSERT_IMPL(a_read_latency, clk, arst_n, in_valid && in_ready && (kind == rhts_pkg::KIND_READ) && !out_valid, ##2 out_valid, "read result late")

endmodule

bind ray_hit_triangle_splatter_unit rhts_checker u_rhts_checker (.*);
